@@ rtl/masked_byte_pattern_scanner_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the masked byte pattern scanner
// Shorthand for clocked implication checks with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SCANNER_MACROS_SVH
`define MASKED_BYTE_PATTERN_SCANNER_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define MBPS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scanner check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define MBPS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scanner check failed");

`endif

@@ rtl/mbps_pkg.sv @@
// ----------------------------------------------------------------------------
// Masked byte pattern scanner package
// Word types, register indexes and shared constants.
// ----------------------------------------------------------------------------
package mbps_pkg;

   localparam int unsigned PATTERN_MAX_DEFAULT = 16;
   localparam int unsigned PAT_BYTES           = 16;
   localparam int unsigned PAT_IDX_W           = 4;
   localparam int unsigned BYTE_W              = 8;
   localparam int unsigned ADDR_W              = 32;
   localparam int unsigned COUNT_W             = 32;
   localparam int unsigned LEN_W               = 5;
   localparam int unsigned MASK_W              = 16;
   localparam int unsigned CSR_INDEX_W         = 3;
   localparam int unsigned CSR_DATA_W          = 64;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SCAN_START   = 3'd0,
      CSR_SCAN_END     = 3'd1,
      CSR_PATTERN_LOW  = 3'd2,
      CSR_PATTERN_HIGH = 3'd3,
      CSR_CARE_MASK    = 3'd4,
      CSR_PATTERN_LEN  = 3'd5,
      CSR_RESULT_LIMIT = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              start_of_scan;
   } req_word_type;

   typedef struct packed {
      logic [ADDR_W-1:0] match_address;
      logic              limit_reached;
   } rsp_word_type;

   // Per-cycle control for the cells of the window chain; shift is shared by all, clear_prev is low in the head cell.
   typedef struct packed {
      logic shift;
      logic clear_prev;
   } cell_ctl_type;

   // Pattern byte and care bit that line up with one cell.
   typedef struct packed {
      logic              care;
      logic [BYTE_W-1:0] pattern_byte;
   } cell_pat_type;

endpackage

@@ rtl/mbps_cell.sv @@
// ----------------------------------------------------------------------------
// Masked byte pattern scanner window cell
// Holds one window byte, takes its neighbor's byte on a shift, and compares
// the incoming byte with its pattern byte.
// ----------------------------------------------------------------------------
module mbps_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  mbps_pkg::cell_ctl_type        ctl,
   input  logic [mbps_pkg::BYTE_W-1:0]   prev_byte,
   input  mbps_pkg::cell_pat_type        pat,
   output logic [mbps_pkg::BYTE_W-1:0]   window_byte,
   output logic                          cell_eq
);
   import mbps_pkg::*;

   logic [BYTE_W-1:0] window_ff;
   logic [BYTE_W-1:0] window_in;
   logic [BYTE_W-1:0] next_byte;

   // drop the neighbor's byte when a new scan clears the window
   assign next_byte = ctl.clear_prev ? '0 : prev_byte;
   assign window_in = ctl.shift ? next_byte : window_ff;
   assign cell_eq   = !pat.care || (next_byte == pat.pattern_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else begin
         window_ff <= window_in;
      end
   end

   assign window_byte = window_ff;

endmodule

@@ rtl/masked_byte_pattern_scanner.sv @@
// ----------------------------------------------------------------------------
// Masked byte pattern scanner
// Scans a byte stream for a pattern with per-byte wildcards and reports the
// start address of each match below a bound, stopping at a match limit.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+---------------------------------
//   req_    | in        | req_valid/req_stall  | data_byte, start_of_scan
//   rsp_    | out       | rsp_valid/rsp_stall  | match_address, limit_reached
//   csr_    | in        | csr_write_en         | csr_index, csr_write_data
//
// One byte is taken per cycle, back to back, while req_stall is low; a match is
// registered in the output or skid register before it shows on rsp_valid. The
// window chain compares in parallel, so the per-byte rate is set by one pass
// through the cells plus the address add and bound compare.
// Reset (synchronous) clears registers, window, counters and the stop flag.
// A stalled result is held in the output register and a second one in a
// skid register; req_stall rises only while the skid register is full.
// ----------------------------------------------------------------------------
`include "masked_byte_pattern_scanner_macros.svh"

module masked_byte_pattern_scanner #(
   parameter int unsigned PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  mbps_pkg::req_word_type            req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output mbps_pkg::rsp_word_type            rsp_word,
   input  logic                              csr_write_en,
   input  mbps_pkg::csr_index_type           csr_index,
   input  logic [mbps_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import mbps_pkg::*;

   // ---------------------------------------------------------------- registers
   logic [ADDR_W-1:0]      scan_start_ff;
   logic [ADDR_W-1:0]      scan_end_ff;
   logic [CSR_DATA_W-1:0]  pattern_low_ff;
   logic [CSR_DATA_W-1:0]  pattern_high_ff;
   logic [MASK_W-1:0]      care_mask_ff;
   logic [LEN_W-1:0]       pattern_length_ff;
   logic [COUNT_W-1:0]     result_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_start_ff     <= '0;
         scan_end_ff       <= '0;
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         care_mask_ff      <= '0;
         pattern_length_ff <= '0;
         result_limit_ff   <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SCAN_START:   scan_start_ff     <= csr_write_data[ADDR_W-1:0];
            CSR_SCAN_END:     scan_end_ff       <= csr_write_data[ADDR_W-1:0];
            CSR_PATTERN_LOW:  pattern_low_ff    <= csr_write_data;
            CSR_PATTERN_HIGH: pattern_high_ff   <= csr_write_data;
            CSR_CARE_MASK:    care_mask_ff      <= csr_write_data[MASK_W-1:0];
            CSR_PATTERN_LEN:  pattern_length_ff <= csr_write_data[LEN_W-1:0];
            CSR_RESULT_LIMIT: result_limit_ff   <= csr_write_data[COUNT_W-1:0];
            default: begin
               // unused index: drop the write
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- pattern
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PATTERN_MAX);

   logic [BYTE_W-1:0] pat_byte [PAT_BYTES];
   logic [LEN_W-1:0]  len_eff;
   logic [LEN_W-1:0]  len_min1;

   always_comb begin
      for (int k = 0; k < PAT_BYTES / 2; k++) begin
         pat_byte[k]                 = pattern_low_ff[k*BYTE_W +: BYTE_W];
         pat_byte[k + PAT_BYTES / 2] = pattern_high_ff[k*BYTE_W +: BYTE_W];
      end
   end

   // clamp the length to the window depth; length zero still names one byte
   assign len_eff  = (pattern_length_ff > LEN_MAX) ? LEN_MAX : pattern_length_ff;
   assign len_min1 = (len_eff == '0) ? LEN_W'(1) : len_eff;

   // ---------------------------------------------------------------- handshake
   logic accept;
   logic sos;
   logic stopped_eff;

   assign accept      = req_valid && !req_stall;
   assign sos         = req_word.start_of_scan;

   // ---------------------------------------------------------------- cell chain
   // Cell j holds window byte j (newest in cell 0). The byte that cell j is
   // about to take lines up with pattern byte len - 1 - j.
   logic [BYTE_W-1:0]      window_q [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] eq_vec;
   logic                   window_hit;

   genvar j;
   generate
      for (j = 0; j < PATTERN_MAX; j++) begin : g_cell
         logic [PAT_IDX_W-1:0] pat_idx;
         cell_ctl_type     ctl;
         cell_pat_type     pat;
         logic [BYTE_W-1:0] prev_byte;

         assign pat_idx          = PAT_IDX_W'(len_eff - LEN_W'(j) - LEN_W'(1));
         assign pat.pattern_byte = pat_byte[pat_idx];
         assign pat.care         = (LEN_W'(j) < len_eff) && care_mask_ff[pat_idx];
         assign ctl.shift        = accept && !stopped_eff;

         if (j == 0) begin : g_head
            assign prev_byte      = req_word.data_byte;
            assign ctl.clear_prev = 1'b0;
         end else begin : g_body
            assign prev_byte      = window_q[j-1];
            assign ctl.clear_prev = sos;
         end

         mbps_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .prev_byte   (prev_byte),
            .pat         (pat),
            .window_byte (window_q[j]),
            .cell_eq     (eq_vec[j])
         );
      end
   endgenerate

   assign window_hit = &eq_vec;

   // ---------------------------------------------------------------- scan state
   logic [COUNT_W-1:0] bytes_seen_ff,   bytes_seen_in;
   logic [COUNT_W-1:0] matches_found_ff, matches_found_in;
   logic               scan_stopped_ff, scan_stopped_in;

   logic [COUNT_W-1:0] seen_eff;
   logic [COUNT_W-1:0] seen_next;
   logic [COUNT_W-1:0] matches_eff;
   logic [COUNT_W-1:0] matches_next;
   logic [COUNT_W-1:0] offset;
   logic [ADDR_W:0]    addr_sum;
   logic               saturated;
   logic               enough;
   logic               in_range;
   logic               limit_hit;
   logic               res_valid;
   rsp_word_type       res_word;

   // a new scan lifts the stop before this byte
   assign stopped_eff  = scan_stopped_ff && !sos;

   // a new scan starts from cleared counters before this byte
   assign seen_eff     = sos ? '0 : bytes_seen_ff;
   assign matches_eff  = sos ? '0 : matches_found_ff;
   assign saturated    = &seen_eff;
   assign seen_next    = seen_eff + COUNT_W'(1);
   assign enough       = seen_next >= COUNT_W'(len_eff);
   assign offset       = seen_next - COUNT_W'(len_min1);
   assign addr_sum     = {1'b0, scan_start_ff} + {1'b0, offset};
   assign in_range     = addr_sum < {1'b0, scan_end_ff};
   assign matches_next = (&matches_eff) ? matches_eff : matches_eff + COUNT_W'(1);
   assign limit_hit    = (result_limit_ff != '0) && (matches_next == result_limit_ff);

   assign res_valid = accept && !stopped_eff && !saturated && enough && in_range
                      && window_hit;
   assign res_word.match_address = addr_sum[ADDR_W-1:0];
   assign res_word.limit_reached = limit_hit;

   always_comb begin
      bytes_seen_in    = bytes_seen_ff;
      matches_found_in = matches_found_ff;
      scan_stopped_in  = scan_stopped_ff;
      if (accept) begin
         // hold everything once stopped; the count sticks at all ones
         bytes_seen_in    = (stopped_eff || saturated) ? seen_eff : seen_next;
         matches_found_in = res_valid ? matches_next : matches_eff;
         scan_stopped_in  = stopped_eff || (res_valid && limit_hit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff    <= '0;
         matches_found_ff <= '0;
         scan_stopped_ff  <= 1'b0;
      end else begin
         bytes_seen_ff    <= bytes_seen_in;
         matches_found_ff <= matches_found_in;
         scan_stopped_ff  <= scan_stopped_in;
      end
   end

   // ---------------------------------------------------------------- output
   // Main output register plus one skid register: a result may still be
   // produced in the cycle the downstream side stalls.
   logic         main_valid_ff, main_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type main_word_ff,  main_word_in;
   rsp_word_type skid_word_ff,  skid_word_in;
   logic         out_take;

   assign out_take  = main_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_word_in  = main_word_ff;
      skid_word_in  = skid_word_ff;
      if (skid_valid_ff) begin
         // advance the skid word once the main word leaves
         if (out_take) begin
            main_word_in  = skid_word_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!main_valid_ff || out_take) begin
         main_valid_in = res_valid;
         main_word_in  = res_word;
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_word_in  = res_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_word_ff <= main_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign rsp_valid = main_valid_ff;
   assign rsp_word  = main_word_ff;

   // ---------------------------------------------------------------- checks
   `MBPS_ASSERT_IMP(a_skid_behind_main, clock, reset, skid_valid_ff, main_valid_ff)
   `MBPS_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, matches_found_ff <= bytes_seen_ff)
   `MBPS_ASSERT_NXT(a_limit_stops, clock, reset, res_valid && limit_hit, scan_stopped_ff)
   `MBPS_ASSERT_NXT(a_seen_grows, clock, reset, accept && !sos, bytes_seen_ff >= $past(bytes_seen_ff))

endmodule
